// ===== sv/fmh_pkg.sv =====
package fmh_pkg;
  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS = 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic {
    OP_COUNT = 1'b0,
    OP_POP = 1'b1
  } op_e;
endpackage

// ===== sv/fmh_if.sv =====
interface fmh_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [31:0] key;
  modport source (output valid, output operation, output key, input ready);
  modport sink (input valid, input operation, input key, output ready);
endinterface

interface fmh_out_if;
  logic valid;
  logic ready;
  logic item_valid;
  logic [31:0] out_key;
  logic [31:0] out_count;
  logic [1:0] status;
  logic [8:0] occupancy;
  modport source (output valid, output item_valid, output out_key, output out_count,
                  output status, output occupancy, input ready);
  modport sink (input valid, input item_valid, input out_key, input out_count,
                input status, input occupancy, output ready);
endinterface

// ===== sv/fmh_ram.sv =====
module fmh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/frequency_max_heap.sv =====
// Frequency counter over a binary max-heap of up to CAPACITY distinct keys held in
// one single-port-read RAM (key and count per word). One transaction at a time:
// a count scans the heap one entry per cycle, then swims up with one read and one
// write per level; a pop reads the top and the last entry and sinks, two reads
// and one write per level. A count of a new key on a full heap reports full, and
// a pop on an empty heap reports empty. The worst case is set by the lookup scan
// through the RAM read port. A result waits in an output register; no clearing
// pass is needed.
module frequency_max_heap #(
  parameter int unsigned CAPACITY = fmh_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = fmh_pkg::KEY_BITS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  fmh_in_if.sink in_i,
  fmh_out_if.source out_o
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned NW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = fmh_pkg::COUNT_BITS;
  localparam int unsigned WW = KEY_BITS + CW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SCAN  = 11'b00000000010,
    S_UPRD  = 11'b00000000100,
    S_UPCMP = 11'b00000001000,
    S_UPWR  = 11'b00000010000,
    S_PTOP  = 11'b00000100000,
    S_PLAST = 11'b00001000000,
    S_DNL   = 11'b00010000000,
    S_DNR   = 11'b00100000000,
    S_DNCMP = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [NW-1:0] total_q, total_d;
  logic [NW:0] idx_q, idx_d;        // node index, wide for child math
  logic [NW:0] ptr_q, ptr_d;        // scan pointer / pending read index
  logic scan_v_q, scan_v_d;         // previous cycle issued a scan read
  logic [KEY_BITS-1:0] cur_key_q, cur_key_d, key_q, key_d;
  logic [CW-1:0] cur_cnt_q, cur_cnt_d;
  logic [WW-1:0] oth_q, oth_d;      // left child entry read during a sink
  logic [NW:0] oth_idx_q, oth_idx_d;
  logic [1:0] wstep_q, wstep_d;
  logic ovalid_q, ovalid_d, oitem_q, oitem_d;
  logic [31:0] okey_q, okey_d, ocnt_q, ocnt_d;
  logic [1:0] ostat_q, ostat_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;
  logic [KEY_BITS-1:0] r_key;
  logic [CW-1:0] r_cnt;
  logic [NW:0] lch, rch, par;

  fmh_ram #(.WIDTH(WW), .DEPTH(CAPACITY)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign r_key = rdata[WW-1:CW];
  assign r_cnt = rdata[CW-1:0];
  assign lch = {idx_q[NW-1:0], 1'b1};
  assign rch = lch + (NW+1)'(1);
  assign par = (idx_q - (NW+1)'(1)) >> 1;

  assign in_i.ready = (state_q == S_IDLE) && !ovalid_q;
  assign out_o.valid = ovalid_q;
  assign out_o.item_valid = oitem_q;
  assign out_o.out_key = okey_q;
  assign out_o.out_count = ocnt_q;
  assign out_o.status = ostat_q;
  assign out_o.occupancy = 9'(total_q);

  always_comb begin
    state_d = state_q; total_d = total_q; idx_d = idx_q; ptr_d = ptr_q;
    scan_v_d = 1'b0; cur_key_d = cur_key_q; cur_cnt_d = cur_cnt_q; key_d = key_q;
    oth_d = oth_q; oth_idx_d = oth_idx_q; wstep_d = wstep_q;
    ovalid_d = ovalid_q; oitem_d = oitem_q; okey_d = okey_q; ocnt_d = ocnt_q;
    ostat_d = ostat_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    if (ovalid_q && out_o.ready) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          oitem_d = 1'b0; okey_d = '0; ocnt_d = '0; ostat_d = fmh_pkg::STATUS_OK;
          key_d = KEY_BITS'(in_i.key);
          if (in_i.operation == fmh_pkg::OP_POP) begin
            if (total_q == '0) begin
              ostat_d = fmh_pkg::STATUS_EMPTY; state_d = S_DONE;
            end else begin
              raddr = '0; state_d = S_PTOP;
            end
          end else begin
            ptr_d = '0; state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue read at ptr, compare the read from the previous cycle
        raddr = AW'(ptr_q);
        if (scan_v_q && r_key == key_q) begin
          idx_d = ptr_q - (NW+1)'(1);
          if (r_cnt == fmh_pkg::COUNT_MAX) begin
            state_d = S_DONE;
          end else begin
            cur_key_d = r_key; cur_cnt_d = r_cnt + CW'(1); state_d = S_UPRD;
          end
        end else if (ptr_q >= (NW+1)'(total_q)) begin
          // every live entry compared without a hit
          if (total_q == NW'(CAPACITY)) begin
            ostat_d = fmh_pkg::STATUS_FULL; state_d = S_DONE;
          end else begin
            idx_d = (NW+1)'(total_q); total_d = total_q + NW'(1);
            cur_key_d = key_q; cur_cnt_d = CW'(1); state_d = S_UPRD;
          end
        end else begin
          scan_v_d = 1'b1; ptr_d = ptr_q + (NW+1)'(1);
        end
      end
      S_UPRD: begin
        if (idx_q == '0) begin
          we = 1'b1; waddr = '0; wdata = {cur_key_q, cur_cnt_q}; state_d = S_DONE;
        end else begin
          raddr = AW'(par); oth_idx_d = par; state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (cur_cnt_q > r_cnt) begin
          we = 1'b1; waddr = AW'(idx_q); wdata = rdata; idx_d = oth_idx_q;
          state_d = S_UPRD;
        end else begin
          we = 1'b1; waddr = AW'(idx_q); wdata = {cur_key_q, cur_cnt_q};
          state_d = S_DONE;
        end
      end
      S_PTOP: begin
        oitem_d = 1'b1; okey_d = 32'(rdata[WW-1:CW]); ocnt_d = r_cnt;
        total_d = total_q - NW'(1);
        raddr = AW'(total_q - NW'(1)); state_d = S_PLAST;
      end
      S_PLAST: begin
        cur_key_d = r_key; cur_cnt_d = r_cnt; idx_d = '0;
        state_d = S_DNL;
        if (total_q == '0) state_d = S_DONE;
      end
      S_DNL: begin
        if (lch >= (NW+1)'(total_q)) begin
          we = 1'b1; waddr = AW'(idx_q); wdata = {cur_key_q, cur_cnt_q};
          state_d = S_DONE;
        end else begin
          raddr = AW'(lch); state_d = S_DNR;
        end
      end
      S_DNR: begin
        oth_d = rdata; oth_idx_d = lch;
        if (rch < (NW+1)'(total_q)) begin
          raddr = AW'(rch); wstep_d = 2'd1;
        end else begin
          wstep_d = 2'd0;
        end
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        logic [WW-1:0] pk;
        logic [NW:0] pi;
        pk = oth_q; pi = oth_idx_q;
        if (wstep_q == 2'd1 && r_cnt > oth_q[CW-1:0]) begin
          pk = rdata; pi = rch;
        end
        if (pk[CW-1:0] > cur_cnt_q) begin
          we = 1'b1; waddr = AW'(idx_q); wdata = pk; idx_d = pi; state_d = S_DNL;
        end else begin
          we = 1'b1; waddr = AW'(idx_q); wdata = {cur_key_q, cur_cnt_q};
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; total_q <= '0; ovalid_q <= 1'b0; scan_v_q <= 1'b0;
    end else begin
      state_q <= state_d; total_q <= total_d; ovalid_q <= ovalid_d;
      scan_v_q <= scan_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; ptr_q <= ptr_d; cur_key_q <= cur_key_d; cur_cnt_q <= cur_cnt_d;
    key_q <= key_d; oth_q <= oth_d; oth_idx_q <= oth_idx_d;
    wstep_q <= wstep_d; oitem_q <= oitem_d; okey_q <= okey_d; ocnt_q <= ocnt_d;
    ostat_q <= ostat_d;
  end

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= NW'(CAPACITY)) else $error("occupancy beyond capacity");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_i.ready) else $error("ready while busy");
  a_pop_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && oitem_q |-> ostat_q == fmh_pkg::STATUS_OK)
    else $error("popped item with error status");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_o.ready |=> ovalid_q && $stable(total_q))
    else $error("result dropped");
endmodule
